FILE: src/drift_poly_table_convert_macros.svh
// Assertion helpers for the checker file.
`ifndef DRIFT_POLY_TABLE_CONVERT_MACROS_SVH
`define DRIFT_POLY_TABLE_CONVERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DPTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dptc_pkg.sv
package dptc_pkg;

    // Default sizing of the table and of the fixed-point format.
    localparam int ENTRIES_DEF        = 256;
    localparam int MAX_COEFS_DEF      = 6;
    localparam int TIME_FRAC_BITS_DEF = 8;

    // Key layout: detector, layer, wire from the top bit down.
    localparam int DET_W   = 7;
    localparam int LAYER_W = 5;
    localparam int WIRE_W  = 8;
    localparam int KEY_W   = DET_W + LAYER_W + WIRE_W;
    localparam int COEF_W  = 64;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 3;

    // Beat widths on the two channels.
    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 4;

    // Request kinds.
    localparam logic REQ_SET     = 1'b0;
    localparam logic REQ_CONVERT = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_WIRE0 = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Match source codes.
    localparam logic [1:0] SRC_EXACT   = 2'd0;
    localparam logic [1:0] SRC_DEFAULT = 2'd1;
    localparam logic [1:0] SRC_NONE    = 2'd2;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_SCAN   = 4'd2,
        OP_SET    = 4'd3,
        OP_PICK   = 4'd4,
        OP_COUNT  = 4'd5,
        OP_RDTOP  = 4'd6,
        OP_LDACC  = 4'd7,
        OP_MUL_LO = 4'd8,
        OP_MUL_HI = 4'd9,
        OP_SUM    = 4'd10,
        OP_ACC    = 4'd11,
        OP_EMIT   = 4'd12
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic is_convert;
        logic have_hit;
        logic cnt_zero;
        logic deg_zero;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: src/drift_poly_table_convert.sv
// Per request: the input beat is loaded, then the key scan reads one table slot per cycle
// over the stored entries. A set then writes its entry; a convert picks the exact or layer
// default entry and, for a non-zero count, loads the top coefficient and runs Horner steps
// (low multiply, high multiply, sum, accumulate) down to degree zero. The result is then
// registered for output. One request in flight: the next beat is taken only after that.
// Reset (aresetn low, synchronous) empties the table and drops any pending result.
module drift_poly_table_convert #(
    parameter int ENTRIES        = dptc_pkg::ENTRIES_DEF,
    parameter int MAX_COEFS      = dptc_pkg::MAX_COEFS_DEF,
    parameter int TIME_FRAC_BITS = dptc_pkg::TIME_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // det_id[6:0], layer_no[11:7], wire_no[19:12], coef_count[22:20],
    // coef_index[25:23], coef_value[89:26], drift_time[121:90], zeros above
    input  logic [dptc_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[0]
    input  logic [dptc_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // drift_length[63:0], coefs_used[66:64], zeros above
    output logic [dptc_pkg::M_TDATA_W-1:0] m_tdata,
    // status[1:0], match_source[3:2]
    output logic [dptc_pkg::M_TUSER_W-1:0] m_tuser
);
    import dptc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dptc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dptc_dp #(
        .ENTRIES        (ENTRIES),
        .MAX_COEFS      (MAX_COEFS),
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: src/dptc_ctrl.sv
module dptc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  dptc_pkg::dp_stat_t stat,
    output dptc_pkg::dp_cmd_t  cmd
);
    import dptc_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_SCAN   = 11'b000_0000_0010,
        ST_DECIDE = 11'b000_0000_0100,
        ST_COUNT  = 11'b000_0000_1000,
        ST_TOP    = 11'b000_0001_0000,
        ST_LOAD   = 11'b000_0010_0000,
        ST_MUL_LO = 11'b000_0100_0000,
        ST_MUL_HI = 11'b000_1000_0000,
        ST_SUM    = 11'b001_0000_0000,
        ST_ACC    = 11'b010_0000_0000,
        ST_EMIT   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Sequencer: one datapath operation per cycle.
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.op = OP_SCAN;
                if (stat.scan_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!stat.is_convert) begin
                    cmd.op     = OP_SET;
                    state_next = ST_EMIT;
                end else begin
                    cmd.op     = OP_PICK;
                    state_next = stat.have_hit ? ST_COUNT : ST_EMIT;
                end
            end
            ST_COUNT: begin
                cmd.op     = OP_COUNT;
                state_next = stat.cnt_zero ? ST_EMIT : ST_TOP;
            end
            ST_TOP: begin
                cmd.op     = OP_RDTOP;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.op     = OP_LDACC;
                state_next = stat.deg_zero ? ST_EMIT : ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd.op     = OP_MUL_LO;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.op     = OP_MUL_HI;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.op     = OP_SUM;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.op     = OP_ACC;
                state_next = stat.deg_zero ? ST_EMIT : ST_MUL_LO;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/dptc_dp.sv
module dptc_dp #(
    parameter int ENTRIES        = dptc_pkg::ENTRIES_DEF,
    parameter int MAX_COEFS      = dptc_pkg::MAX_COEFS_DEF,
    parameter int TIME_FRAC_BITS = dptc_pkg::TIME_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dptc_pkg::dp_cmd_t              cmd,
    output dptc_pkg::dp_stat_t             stat,
    input  logic [dptc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [dptc_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dptc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [dptc_pkg::M_TUSER_W-1:0] m_tuser
);
    import dptc_pkg::*;

    localparam int SW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW      = $clog2(ENTRIES + 1);
    localparam int CDEPTH  = ENTRIES * MAX_COEFS;
    localparam int CW      = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int HSH     = 12 + TIME_FRAC_BITS;
    localparam int PASS_SH = 32 - TIME_FRAC_BITS;

    // Calibration storage.
    logic [KEY_W-1:0]  key_mem  [ENTRIES];
    logic [CNT_W-1:0]  cnt_mem  [ENTRIES];
    logic [COEF_W-1:0] coef_mem [CDEPTH];

    // Captured request.
    logic                     convert_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [CNT_W-1:0]         cnt_in_reg;
    logic [CNT_W-1:0]         idx_reg;
    logic [COEF_W-1:0]        value_reg;
    logic signed [TIME_W-1:0] time_reg;

    // Table fill and key scan.
    logic [FW-1:0]    fill_reg;
    logic [FW-1:0]    scan_cnt_reg;
    logic             cmp_vld_reg;
    logic [SW-1:0]    cmp_slot_reg;
    logic [KEY_W-1:0] key_q_reg;
    logic             exact_hit_reg, def_hit_reg;
    logic [SW-1:0]    exact_slot_reg, def_slot_reg;

    // Evaluation.
    logic [SW-1:0]            sel_slot_reg;
    logic [CNT_W-1:0]         cnt_q_reg;
    logic [CNT_W-1:0]         deg_reg;
    logic [COEF_W-1:0]        coef_q_reg;
    logic signed [64:0]       mul_reg;
    logic signed [64:0]       plo_reg;
    logic signed [95:0]       prod_reg;

    // Result staging and output register.
    logic [1:0]        res_status_reg, res_source_reg;
    logic [CNT_W-1:0]  res_used_reg;
    logic [COEF_W-1:0] len_reg;
    logic              out_valid_reg;
    logic [1:0]        out_status_reg, out_source_reg;
    logic [CNT_W-1:0]  out_used_reg;
    logic [COEF_W-1:0] out_len_reg;

    logic [KEY_W-1:0]   def_key;
    logic [SW-1:0]      scan_addr;
    logic               scan_live;
    logic [CNT_W-1:0]   cnt_clamp;
    logic               idx_ok;
    logic [SW-1:0]      set_slot;
    logic [SW-1:0]      pick_slot;
    logic [CNT_W-1:0]   rd_deg;
    logic [CW-1:0]      rd_addr;
    logic [CW-1:0]      wr_addr;
    logic signed [32:0] mul_a;
    logic signed [64:0] mul_res;
    logic signed [95:0] prod_sh;
    logic signed [63:0] term_sat;
    logic signed [64:0] acc_sum;
    logic [COEF_W-1:0]  acc_new;
    logic [COEF_W-1:0]  pass_len;

    assign def_key   = {key_reg[KEY_W-1:WIRE_W], {WIRE_W{1'b0}}};
    assign scan_addr = scan_cnt_reg[SW-1:0];
    assign scan_live = (scan_cnt_reg < fill_reg);

    // Count is held to the table's coefficient depth; higher degrees are dropped.
    assign cnt_clamp = ({1'b0, cnt_in_reg} > 4'(MAX_COEFS)) ? CNT_W'(MAX_COEFS) : cnt_in_reg;
    assign idx_ok    = ({1'b0, idx_reg} < 4'(MAX_COEFS));
    assign set_slot  = exact_hit_reg ? exact_slot_reg : fill_reg[SW-1:0];
    assign pick_slot = exact_hit_reg ? exact_slot_reg : def_slot_reg;

    // Coefficient addresses: slot times depth plus degree.
    assign rd_deg  = (cmd.op == OP_MUL_LO) ? (deg_reg - 1'b1) : deg_reg;
    assign rd_addr = CW'(sel_slot_reg) * CW'(MAX_COEFS) + CW'(rd_deg);
    assign wr_addr = CW'(set_slot) * CW'(MAX_COEFS) + CW'(idx_reg);

    // Shared multiplier: low word unsigned, then high word signed.
    assign mul_a   = (cmd.op == OP_MUL_LO) ? $signed({1'b0, len_reg[31:0]})
                                           : $signed({len_reg[63], len_reg[63:32]});
    assign mul_res = mul_a * time_reg;

    // Arithmetic shift, saturation to 64 bits, then saturating add.
    assign prod_sh  = prod_reg >>> HSH;
    assign term_sat = ((&prod_sh[95:63]) || !(|prod_sh[95:63])) ? prod_sh[63:0]
                    : (prod_sh[95] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});
    assign acc_sum  = $signed({coef_q_reg[63], coef_q_reg}) + $signed({term_sat[63], term_sat});
    assign acc_new  = (acc_sum[64] == acc_sum[63]) ? acc_sum[63:0]
                    : (acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});

    assign pass_len = {{32{time_reg[31]}}, time_reg} << PASS_SH;

    // Status towards the controller.
    always_comb begin
        stat.scan_done  = !scan_live && !cmp_vld_reg;
        stat.is_convert = convert_reg;
        stat.have_hit   = exact_hit_reg || def_hit_reg;
        stat.cnt_zero   = (cnt_q_reg == '0);
        stat.deg_zero   = (deg_reg == '0);
        stat.out_free   = !out_valid_reg || m_tready;
    end

    // Request capture.
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            convert_reg <= s_tuser[0];
            key_reg     <= {s_tdata[6:0], s_tdata[11:7], s_tdata[19:12]};
            cnt_in_reg  <= s_tdata[22:20];
            idx_reg     <= s_tdata[25:23];
            value_reg   <= s_tdata[89:26];
            time_reg    <= s_tdata[121:90];
        end
    end

    // Key scan: one slot read per cycle, compared in the following cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            exact_hit_reg <= 1'b0;
            def_hit_reg   <= 1'b0;
        end else if (cmd.op == OP_LOAD) begin
            scan_cnt_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            exact_hit_reg <= 1'b0;
            def_hit_reg   <= 1'b0;
        end else begin
            cmp_vld_reg <= (cmd.op == OP_SCAN) && scan_live;
            if ((cmd.op == OP_SCAN) && scan_live) begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if (cmp_vld_reg && !exact_hit_reg && (key_q_reg == key_reg)) begin
                exact_hit_reg <= 1'b1;
            end
            if (cmp_vld_reg && !def_hit_reg && (key_q_reg == def_key)) begin
                def_hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmp_slot_reg <= scan_addr;
        if (cmp_vld_reg && !exact_hit_reg && (key_q_reg == key_reg)) begin
            exact_slot_reg <= cmp_slot_reg;
        end
        if (cmp_vld_reg && !def_hit_reg && (key_q_reg == def_key)) begin
            def_slot_reg <= cmp_slot_reg;
        end
    end

    // Key memory: scan read, write on insertion.
    always_ff @(posedge aclk) begin
        if ((cmd.op == OP_SCAN) && scan_live) begin
            key_q_reg <= key_mem[scan_addr];
        end
        if ((cmd.op == OP_SET) && !exact_hit_reg && (key_reg[WIRE_W-1:0] != '0)
                && (fill_reg < FW'(ENTRIES))) begin
            key_mem[set_slot] <= key_reg;
        end
    end

    // Count memory.
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_PICK) begin
            cnt_q_reg <= cnt_mem[pick_slot];
        end
        if ((cmd.op == OP_SET) && (exact_hit_reg || ((key_reg[WIRE_W-1:0] != '0)
                && (fill_reg < FW'(ENTRIES))))) begin
            cnt_mem[set_slot] <= cnt_clamp;
        end
    end

    // Coefficient memory.
    always_ff @(posedge aclk) begin
        if ((cmd.op == OP_RDTOP) || (cmd.op == OP_MUL_LO)) begin
            coef_q_reg <= coef_mem[rd_addr];
        end
        if ((cmd.op == OP_SET) && idx_ok && (exact_hit_reg || ((key_reg[WIRE_W-1:0] != '0)
                && (fill_reg < FW'(ENTRIES))))) begin
            coef_mem[wr_addr] <= value_reg;
        end
    end

    // Fill count: slots are taken in order and never freed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if ((cmd.op == OP_SET) && !exact_hit_reg && (key_reg[WIRE_W-1:0] != '0)
                && (fill_reg < FW'(ENTRIES))) begin
            fill_reg <= fill_reg + 1'b1;
        end
    end

    // Result staging and Horner evaluation.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_SET: begin
                res_source_reg <= SRC_EXACT;
                res_used_reg   <= '0;
                len_reg        <= '0;
                if (exact_hit_reg) begin
                    res_status_reg <= ST_OK;
                end else if (key_reg[WIRE_W-1:0] == '0) begin
                    res_status_reg <= ST_WIRE0;
                end else if (fill_reg < FW'(ENTRIES)) begin
                    res_status_reg <= ST_OK;
                end else begin
                    res_status_reg <= ST_FULL;
                end
            end
            OP_PICK: begin
                res_status_reg <= ST_OK;
                res_used_reg   <= '0;
                len_reg        <= pass_len;
                sel_slot_reg   <= pick_slot;
                if (exact_hit_reg) begin
                    res_source_reg <= SRC_EXACT;
                end else if (def_hit_reg) begin
                    res_source_reg <= SRC_DEFAULT;
                end else begin
                    res_source_reg <= SRC_NONE;
                end
            end
            OP_COUNT: begin
                res_used_reg <= cnt_q_reg;
                deg_reg      <= cnt_q_reg - 1'b1;
                len_reg      <= '0;
            end
            OP_LDACC: begin
                len_reg <= coef_q_reg;
            end
            OP_MUL_LO: begin
                mul_reg <= mul_res;
                deg_reg <= deg_reg - 1'b1;
            end
            OP_MUL_HI: begin
                plo_reg <= mul_reg;
                mul_reg <= mul_res;
            end
            OP_SUM: begin
                prod_reg <= $signed({mul_reg[63:0], 32'd0}) + $signed({{31{plo_reg[64]}}, plo_reg});
            end
            OP_ACC: begin
                len_reg <= acc_new;
            end
            default: begin
            end
        endcase
    end

    // Output register: holds one result beat while the sink stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == OP_EMIT) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_EMIT) begin
            out_status_reg <= res_status_reg;
            out_source_reg <= res_source_reg;
            out_used_reg   <= res_used_reg;
            out_len_reg    <= len_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_used_reg, out_len_reg};
    assign m_tuser  = {out_source_reg, out_status_reg};

endmodule

FILE: src/dptc_checker.sv
`include "drift_poly_table_convert_macros.svh"

module dptc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [dptc_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [dptc_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dptc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [dptc_pkg::M_TUSER_W-1:0] m_tuser
);
    import dptc_pkg::*;

    // A stalled result beat stays and keeps its contents.
    `DPTC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    // A refused set carries a zero length and the exact source code.
    `DPTC_ASSERT_NOW(a_refused_clean, m_tvalid && (m_tuser[1:0] != ST_OK), (m_tdata[63:0] == 64'd0) && (m_tuser[3:2] == SRC_EXACT), "refused set with non-zero fields")

    // A convert without an entry reports no coefficients.
    `DPTC_ASSERT_NOW(a_none_unused, m_tvalid && (m_tuser[3:2] == SRC_NONE), m_tdata[66:64] == 3'd0, "no-entry result with coefficients")

    // One request at a time: the input is closed in the cycle after a beat is accepted.
    `DPTC_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input taken twice in a row")

endmodule

bind drift_poly_table_convert dptc_checker u_dptc_checker (.*);

FILE: sim/drift_poly_table_convert_tb.sv
module drift_poly_table_convert_tb;
    import dptc_pkg::*;

    localparam int NUM_SLOTS   = ENTRIES_DEF;
    localparam int NUM_COEFS   = MAX_COEFS_DEF;
    localparam int HORNER_SH   = 12 + TIME_FRAC_BITS_DEF;
    localparam int PASS_SH     = 32 - TIME_FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int MAX_GAP     = 13;

    // One calibration request as it travels on the input channel.
    typedef struct {
        logic             kind;
        logic [6:0]       det;
        logic [4:0]       layer;
        logic [7:0]       wire_no;
        logic [2:0]       cnt;
        logic [2:0]       idx;
        logic [63:0]      coef;
        logic [31:0]      dtime;
    } calib_req_t;

    // One expected reply of the block.
    typedef struct {
        logic [1:0]  status;
        logic [63:0] length;
        logic [1:0]  source;
        logic [2:0]  used;
    } calib_reply_t;

    // Mirror of the calibration table with the queue of replies still owed.
    class calib_scoreboard;
        bit               slot_vld[NUM_SLOTS];
        logic [19:0]      slot_key[NUM_SLOTS];
        int               slot_cnt[NUM_SLOTS];
        logic [63:0]      slot_coef[NUM_SLOTS][NUM_COEFS];
        bit [7:0]         slot_written[NUM_SLOTS];
        int               fill;
        int               mismatches;
        calib_reply_t     owed[$];

        function new();
            fill = 0;
            mismatches = 0;
            foreach (slot_vld[s]) begin
                slot_vld[s] = 0;
                slot_written[s] = '0;
            end
        endfunction

        function int find_slot(logic [19:0] key);
            for (int s = 0; s < NUM_SLOTS; s++) begin
                if (slot_vld[s] && slot_key[s] == key) return s;
            end
            return -1;
        endfunction

        // Longest run of written degrees from zero once this write has landed.
        function int coef_prefix(logic [19:0] key, int idx);
            int s;
            bit [7:0] m;
            int n;
            s = find_slot(key);
            m = (s >= 0) ? slot_written[s] : 8'd0;
            if (idx < NUM_COEFS) m[idx] = 1'b1;
            n = 0;
            while (n < NUM_COEFS && m[n]) n++;
            return n;
        endfunction

        function logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [64:0] s;
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            return s[63:0];
        endfunction

        function logic signed [63:0] mul_shift_sat(logic signed [63:0] a,
                                                   logic signed [31:0] t);
            logic signed [95:0] pa, pt, p;
            pa = a;
            pt = t;
            p = (pa * pt) >>> HORNER_SH;
            if (&p[95:63] || ~|p[95:63]) return p[63:0];
            return p[95] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        endfunction

        function logic signed [63:0] horner(int s, logic signed [31:0] t);
            logic signed [63:0] acc;
            int n;
            n = slot_cnt[s];
            if (n == 0) return 64'sd0;
            acc = slot_coef[s][n-1];
            for (int i = n - 1; i > 0; i--) begin
                acc = add_sat(slot_coef[s][i-1], mul_shift_sat(acc, t));
            end
            return acc;
        endfunction

        // Apply an accepted request to the table and queue its reply.
        function void note_request(calib_req_t r);
            calib_reply_t e;
            logic [19:0] key;
            int s, f, c;
            logic signed [63:0] t64;
            key = {r.det, r.layer, r.wire_no};
            e = '{ST_OK, 64'd0, SRC_EXACT, 3'd0};
            if (r.kind == REQ_SET) begin
                c = (r.cnt > NUM_COEFS) ? NUM_COEFS : r.cnt;
                s = find_slot(key);
                if (s < 0) begin
                    if (r.wire_no == 8'd0) begin
                        e.status = ST_WIRE0;
                    end else begin
                        f = 0;
                        while (f < NUM_SLOTS && slot_vld[f]) f++;
                        if (f < NUM_SLOTS) begin
                            slot_vld[f] = 1;
                            slot_key[f] = key;
                            slot_written[f] = '0;
                            fill++;
                            s = f;
                        end else begin
                            e.status = ST_FULL;
                        end
                    end
                end
                if (s >= 0) begin
                    slot_cnt[s] = c;
                    if (r.idx < NUM_COEFS) begin
                        slot_coef[s][r.idx] = r.coef;
                        slot_written[s][r.idx] = 1'b1;
                    end
                end
            end else begin
                s = find_slot(key);
                e.source = SRC_EXACT;
                if (s < 0) begin
                    s = find_slot({key[19:8], 8'd0});
                    e.source = SRC_DEFAULT;
                end
                if (s >= 0) begin
                    e.length = horner(s, r.dtime);
                    e.used = 3'(slot_cnt[s]);
                end else begin
                    t64 = $signed(r.dtime);
                    e.source = SRC_NONE;
                    e.length = t64 <<< PASS_SH;
                end
            end
            owed.push_back(e);
        endfunction

        function void report(string what, calib_reply_t e, calib_reply_t a);
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch (%s): expected st=%0d len=%h src=%0d used=%0d,",
                          " got st=%0d len=%h src=%0d used=%0d"},
                         what, e.status, e.length, e.source, e.used,
                         a.status, a.length, a.source, a.used);
        endfunction

        // Compare a reply beat with the oldest reply owed.
        function void check_reply(calib_reply_t a);
            calib_reply_t e;
            if (owed.size() == 0) begin
                e = '{0, 0, 0, 0};
                report("no reply owed", e, a);
                return;
            end
            e = owed.pop_front();
            if (a.status != e.status) report("status", e, a);
            else if (a.length != e.length) report("drift_length", e, a);
            else if (a.source != e.source) report("match_source", e, a);
            else if (a.used != e.used) report("coefs_used", e, a);
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    calib_scoreboard sb = new();
    int  cycles = 0;
    bit  burst_in = 0;
    bit  burst_out = 0;

    drift_poly_table_convert dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #4 aclk = ~aclk;

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Drive one request beat; entered and left at a falling edge.
    task automatic send_req(calib_req_t r);
        int gap;
        gap = draw_gap(burst_in);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {6'd0, r.dtime, r.coef, r.idx, r.cnt, r.wire_no, r.layer, r.det};
        s_tuser  <= r.kind;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
        @(negedge aclk);
    endtask

    task automatic set_coef(logic [6:0] d, logic [4:0] l, logic [7:0] w,
                            logic [2:0] c, logic [2:0] i, logic [63:0] v);
        calib_req_t r;
        r = '{REQ_SET, d, l, w, c, i, v, $urandom()};
        send_req(r);
    endtask

    task automatic convert(logic [6:0] d, logic [4:0] l, logic [7:0] w, logic [31:0] t);
        calib_req_t r;
        r = '{REQ_CONVERT, d, l, w, 3'($urandom()), 3'($urandom()),
              {$urandom(), $urandom()}, t};
        send_req(r);
    endtask

    function logic [63:0] rand_coef(int deg);
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = {$urandom(), $urandom()};
            1: v = $urandom_range(0, 1) ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            default: v = {{32{1'b0}}, $urandom()} >> (deg * 4);
        endcase
        if (v[63] == 1'b0 && $urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    function logic [31:0] rand_time();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                 : -$urandom_range(0, 65535);
        endcase
    endfunction

    // Keys from a small pool, so that most lookups find an entry.
    task automatic pool_key(output logic [6:0] d, output logic [4:0] l, output logic [7:0] w);
        case ($urandom_range(0, 3))
            0: d = 7'd0;
            1: d = 7'h7f;
            default: d = 7'($urandom_range(1, 2));
        endcase
        case ($urandom_range(0, 3))
            0: l = 5'd0;
            1: l = 5'h1f;
            default: l = 5'($urandom_range(1, 2));
        endcase
        case ($urandom_range(0, 4))
            0: w = 8'd0;
            1: w = 8'hff;
            default: w = 8'($urandom_range(1, 3));
        endcase
    endtask

    // One random request: a coefficient write that keeps counts covered, or a lookup.
    task automatic random_req(bit wild_keys);
        logic [6:0] d;
        logic [4:0] l;
        logic [7:0] w;
        int i, n, c;
        pool_key(d, l, w);
        if (wild_keys && $urandom_range(0, 3) == 0) begin
            d = 7'($urandom());
            l = 5'($urandom());
            w = 8'($urandom());
        end
        if ($urandom_range(0, 19) == 0) burst_in = ~burst_in;
        if ($urandom_range(0, 99) < 45) begin
            i = $urandom_range(0, 7);
            n = sb.coef_prefix({d, l, w}, i);
            c = (n == NUM_COEFS && $urandom_range(0, 2) == 0) ? 7 : $urandom_range(0, n);
            set_coef(d, l, w, 3'(c), 3'(i), rand_coef(i));
        end else begin
            convert(d, l, w, rand_time());
        end
    endtask

    // Result side: random stalls, then take one beat and check it.
    initial begin
        calib_reply_t a;
        int stall;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 19) == 0) burst_out = ~burst_out;
            stall = draw_gap(burst_out);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            a.status = m_tuser[1:0];
            a.source = m_tuser[3:2];
            a.length = m_tdata[63:0];
            a.used   = m_tdata[66:64];
            sb.check_reply(a);
            @(negedge aclk);
        end
    end

    // Stimulus and end of run.
    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: build one full entry, probe the special cases.
        set_coef(7'd9, 5'd4, 8'd0, 3'd1, 3'd0, 64'd1);          // new layer default is refused
        set_coef(7'd9, 5'd4, 8'd7, 3'd0, 3'd7, 64'd5);          // insert with ignored index
        convert(7'd9, 5'd4, 8'd7, 32'd1000);                    // count zero gives zero length
        set_coef(7'd9, 5'd4, 8'd7, 3'd1, 3'd0, {1'b0, {63{1'b1}}});
        convert(7'd9, 5'd4, 8'd7, 32'h7fff_ffff);
        set_coef(7'd9, 5'd4, 8'd7, 3'd2, 3'd1, {1'b1, 63'd0});
        set_coef(7'd9, 5'd4, 8'd7, 3'd3, 3'd2, 64'h0000_0100_0000_0000);
        set_coef(7'd9, 5'd4, 8'd7, 3'd4, 3'd3, -64'sd12345678);
        set_coef(7'd9, 5'd4, 8'd7, 3'd5, 3'd4, 64'd77777);
        set_coef(7'd9, 5'd4, 8'd7, 3'd6, 3'd5, 64'hffff_ffff_ffff_fff0);
        set_coef(7'd9, 5'd4, 8'd7, 3'd7, 3'd6, 64'd3);          // count clipped, index ignored
        convert(7'd9, 5'd4, 8'd7, 32'h8000_0000);
        convert(7'd9, 5'd4, 8'd7, 32'h7fff_ffff);
        convert(7'd9, 5'd4, 8'd7, 32'd0);
        convert(7'd9, 5'd4, 8'd7, 32'hffff_ff00);
        set_coef(7'd9, 5'd4, 8'd7, 3'd2, 3'd0, 64'd42);         // overwrite of an existing key
        convert(7'd9, 5'd4, 8'd7, 32'd256);
        convert(7'd9, 5'd4, 8'd0, 32'd256);                     // wire zero lookup
        convert(7'd9, 5'd4, 8'd99, 32'd512);                    // no exact, no default
        convert(7'h7f, 5'h1f, 8'hff, 32'h8000_0000);            // nothing stored: time passed
        convert(7'h00, 5'h00, 8'h00, 32'h7fff_ffff);

        // Random traffic on a small key pool.
        repeat (650) random_req(1'b0);

        // Fill the table with fresh keys until no slot is left.
        while (sb.fill < NUM_SLOTS) begin
            if ($urandom_range(0, 9) == 0) begin
                convert(7'($urandom()), 5'($urandom()), 8'($urandom()), rand_time());
            end else begin
                set_coef(7'($urandom()), 5'($urandom()), 8'($urandom_range(1, 255)),
                         3'd1, 3'd0, rand_coef(0));
            end
        end

        // Random traffic against a full table, new keys now refused.
        repeat (600) random_req(1'b1);

        s_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
